// ===== rtl/hwe_pkg.sv =====
// ----------------------------------------------------------------------------
// hwe_pkg: shared types and constants
// Item structs, register indexes and fixed-point constants for the
// Hardy-Weinberg allele frequency estimator.
// ----------------------------------------------------------------------------
package hwe_pkg;

   localparam int MaxSamplesDefault = 1024;
   localparam int ProbBits = 32;
   localparam int FracBits = ProbBits - 1;
   localparam logic [ProbBits-1:0] One = ProbBits'(64'd1 << FracBits);

   localparam logic [1:0] CsrMaxIter = 2'd0;
   localparam logic [1:0] CsrEpsilon = 2'd1;
   localparam logic [1:0] CsrInitFreq = 2'd2;

   typedef struct packed {
      logic        sample_missing;
      logic        sample_haploid;
      logic [31:0] lik_first;
      logic [31:0] lik_het;
      logic [31:0] lik_second;
      logic        last_sample;
   } req_type;

   typedef struct packed {
      logic [31:0] allele_frequency;
      logic [15:0] iterations_used;
      logic        converged;
      logic        no_data;
      logic        degenerate_sample;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic store;      // write incoming item
      logic clear;      // clear loaded count and flags for new population
      logic em_start;   // begin an EM run
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic em_done;
   } sts_type;

   function automatic logic [31:0] sat_one(input logic [31:0] v);
      sat_one = (v > One) ? One : v;
   endfunction

endpackage

// ===== rtl/hwe_div.sv =====
// ----------------------------------------------------------------------------
// hwe_div: restoring divider
// Unsigned 64 / 34 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hwe_div
   import hwe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [33:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] quo_ff, quo_in;
   logic [34:0] rem_ff, rem_in;
   logic [33:0] div_ff, div_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [34:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      trial = {rem_ff[33:0], quo_ff[63]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = 7'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== rtl/hwe_datapath.sv =====
// ----------------------------------------------------------------------------
// hwe_datapath: sample store and EM engine
// Holds the population's samples in memory and runs the EM iterations
// with one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
module hwe_datapath
   import hwe_pkg::*;
#(
   parameter int MaxSamples = MaxSamplesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  req_type     req,
   input  logic [15:0] max_iter,
   input  logic [31:0] epsilon,
   input  logic [31:0] init_freq,
   output sts_type     sts,
   output rsp_type     result
);
   localparam int AW = $clog2(MaxSamples);
   localparam int CW = $clog2(MaxSamples + 1);

   typedef enum logic [14:0] {
      E_IDLE  = 15'h0001,
      E_ITER  = 15'h0002,
      E_READ  = 15'h0004,
      E_WAIT  = 15'h0008,
      E_M1    = 15'h0010,
      E_M2    = 15'h0020,
      E_M3    = 15'h0040,
      E_M4    = 15'h0080,
      E_M5    = 15'h0100,
      E_SUM   = 15'h0200,
      E_DIV1  = 15'h0400,
      E_DIV2  = 15'h0800,
      E_NEXT  = 15'h1000,
      E_FDIV  = 15'h2000,
      E_DONE  = 15'h4000
   } em_state_type;

   logic [31:0] first_mem [MaxSamples];
   logic [31:0] het_mem [MaxSamples];
   logic [31:0] second_mem [MaxSamples];
   logic [1:0]  flag_mem [MaxSamples];
   logic [31:0] rd_first, rd_het, rd_second;
   logic [1:0]  rd_flag;

   em_state_type st_ff, st_in;
   logic [CW-1:0] count_ff, count_in;
   logic          any_ff, any_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [31:0]   f_ff, f_in, g_ff, g_in;
   logic [31:0]   ff_ff, ff_in, gg_ff, gg_in, fg2_ff, fg2_in;
   logic [31:0]   w0_ff, w0_in, w1_ff, w1_in, w2_ff, w2_in;
   logic [33:0]   sum_ff, sum_in;
   logic [63:0]   acc_ff, acc_in;
   logic [CW+1:0] copies_ff, copies_in;
   logic [15:0]   iter_ff, iter_in;
   logic          conv_ff, conv_in, degen_ff, degen_in;
   logic          done_ff, done_in;
   logic [31:0]   ma, mb;
   logic [63:0]   prod;
   logic [31:0]   prod_q;
   logic          div_go;
   logic [63:0]   div_num;
   logic [33:0]   div_den;
   logic          div_done;
   logic [63:0]   div_q;
   logic [31:0]   nf, diff;
   logic [CW-1:0] last_idx;

   // sample store
   always_ff @(posedge clock) begin
      if (cmd.store && count_ff < CW'(MaxSamples)) begin
         first_mem[count_ff[AW-1:0]] <= sat_one(req.lik_first);
         het_mem[count_ff[AW-1:0]] <= sat_one(req.lik_het);
         second_mem[count_ff[AW-1:0]] <= sat_one(req.lik_second);
         flag_mem[count_ff[AW-1:0]] <= {req.sample_haploid, req.sample_missing};
      end
      rd_first <= first_mem[idx_ff];
      rd_het <= het_mem[idx_ff];
      rd_second <= second_mem[idx_ff];
      rd_flag <= flag_mem[idx_ff];
   end

   assign prod = ma * mb;
   assign prod_q = prod[62:31];
   assign last_idx = count_ff - CW'(1);

   hwe_div u_div (
      .clock(clock), .reset(reset), .start(div_go), .dividend(div_num),
      .divisor(div_den), .done(div_done), .quotient(div_q)
   );

   always_comb begin
      st_in = st_ff;
      count_in = count_ff;
      any_in = any_ff;
      idx_in = idx_ff;
      f_in = f_ff; g_in = g_ff;
      ff_in = ff_ff; gg_in = gg_ff; fg2_in = fg2_ff;
      w0_in = w0_ff; w1_in = w1_ff; w2_in = w2_ff;
      sum_in = sum_ff;
      acc_in = acc_ff;
      copies_in = copies_ff;
      iter_in = iter_ff;
      conv_in = conv_ff;
      degen_in = degen_ff;
      done_in = 1'b0;
      ma = '0; mb = '0;
      div_go = 1'b0;
      div_num = '0;
      div_den = sum_ff;
      nf = f_ff;
      diff = '0;

      if (cmd.clear) begin
         count_in = '0;
         any_in = 1'b0;
      end else if (cmd.store && count_ff < CW'(MaxSamples)) begin
         count_in = count_ff + CW'(1);
         if (!req.sample_missing) any_in = 1'b1;
      end

      case (st_ff)
         E_IDLE: begin
            if (cmd.em_start) begin
               f_in = sat_one(init_freq);
               iter_in = '0;
               conv_in = 1'b0;
               degen_in = 1'b0;
               // the closing sample counts too
               if (!any_in) begin
                  f_in = '0;
                  st_in = E_DONE;
               end else if (max_iter == 16'd0) begin
                  st_in = E_DONE;
               end else begin
                  st_in = E_ITER;
               end
            end
         end
         E_ITER: begin
            // per-iteration priors: g, f*f, g*g, 2fg
            g_in = One - f_ff;
            idx_in = '0;
            acc_in = '0;
            copies_in = '0;
            st_in = E_M1;
         end
         E_M1: begin
            ma = f_ff; mb = f_ff; ff_in = prod_q;
            st_in = E_M2;
         end
         E_M2: begin
            ma = g_ff; mb = g_ff; gg_in = prod_q;
            st_in = E_M3;
         end
         E_M3: begin
            ma = f_ff; mb = g_ff;
            fg2_in = prod[61:30];
            st_in = E_READ;
         end
         E_READ: st_in = E_WAIT;
         E_WAIT: begin
            if (rd_flag[0]) begin
               st_in = E_NEXT;
            end else begin
               ma = rd_first; mb = rd_flag[1] ? g_ff : gg_ff;
               w0_in = prod_q;
               st_in = E_M4;
            end
         end
         E_M4: begin
            ma = rd_flag[1] ? rd_second : rd_het;
            mb = rd_flag[1] ? f_ff : fg2_ff;
            w1_in = prod_q;
            st_in = E_M5;
         end
         E_M5: begin
            ma = rd_second; mb = ff_ff;
            w2_in = rd_flag[1] ? 32'd0 : prod_q;
            st_in = E_SUM;
         end
         E_SUM: begin
            sum_in = 34'(w0_ff) + 34'(w1_ff) + 34'(w2_ff);
            if (sum_in == '0) begin
               degen_in = 1'b1;
               st_in = E_NEXT;
            end else begin
               div_go = 1'b1;
               div_den = sum_in;
               div_num = {1'b0, w1_ff, 31'd0};
               copies_in = copies_ff + (rd_flag[1] ? (CW+2)'(1) : (CW+2)'(2));
               st_in = E_DIV1;
            end
         end
         E_DIV1: begin
            if (div_done) begin
               acc_in = acc_ff + div_q;
               if (rd_flag[1]) begin
                  st_in = E_NEXT;
               end else begin
                  div_go = 1'b1;
                  div_num = {1'b0, w2_ff, 31'd0};
                  st_in = E_DIV2;
               end
            end
         end
         E_DIV2: begin
            if (div_done) begin
               acc_in = acc_ff + {div_q[62:0], 1'b0};
               st_in = E_NEXT;
            end
         end
         E_NEXT: begin
            if (CW'(idx_ff) == last_idx) begin
               if (copies_ff == '0) begin
                  st_in = E_FDIV;
               end else begin
                  div_go = 1'b1;
                  div_num = acc_ff;
                  div_den = 34'(copies_ff);
                  st_in = E_FDIV;
               end
            end else begin
               idx_in = idx_ff + AW'(1);
               st_in = E_READ;
            end
         end
         E_FDIV: begin
            if (copies_ff == '0 || div_done) begin
               if (copies_ff != '0)
                  nf = (div_q > 64'(One)) ? One : div_q[31:0];
               diff = (nf > f_ff) ? nf - f_ff : f_ff - nf;
               f_in = nf;
               iter_in = iter_ff + 16'd1;
               if (diff <= epsilon) begin
                  conv_in = 1'b1;
                  st_in = E_DONE;
               end else if (iter_in >= max_iter) begin
                  st_in = E_DONE;
               end else begin
                  st_in = E_ITER;
               end
            end
         end
         E_DONE: begin
            done_in = 1'b1;
            st_in = E_IDLE;
         end
         default: st_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      f_ff <= f_in; g_ff <= g_in;
      ff_ff <= ff_in; gg_ff <= gg_in; fg2_ff <= fg2_in;
      w0_ff <= w0_in; w1_ff <= w1_in; w2_ff <= w2_in;
      sum_ff <= sum_in;
      acc_ff <= acc_in;
      copies_ff <= copies_in;
      iter_ff <= iter_in;
      conv_ff <= conv_in;
      degen_ff <= degen_in;
      if (reset) begin
         st_ff <= E_IDLE;
         count_ff <= '0;
         any_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         count_ff <= count_in;
         any_ff <= any_in;
         done_ff <= done_in;
      end
   end

   assign sts.em_done = done_ff;
   assign result.allele_frequency = f_ff;
   assign result.iterations_used = iter_ff;
   assign result.converged = conv_ff;
   assign result.no_data = ~any_ff;
   assign result.degenerate_sample = degen_ff;
endmodule

// ===== rtl/hwe_ctrl.sv =====
// ----------------------------------------------------------------------------
// hwe_ctrl: sequencing controller
// Loads samples, launches EM on the last one and issues the result strobe.
// ----------------------------------------------------------------------------
module hwe_ctrl
   import hwe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    last,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy,
   output logic    rsp_valid
);
   typedef enum logic [2:0] {
      S_LOAD = 3'b001,
      S_EM   = 3'b010,
      S_OUT  = 3'b100
   } state_type;

   state_type st_ff, st_in;

   always_comb begin
      st_in = st_ff;
      cmd = '0;
      case (st_ff)
         S_LOAD: begin
            if (start) begin
               cmd.store = 1'b1;
               if (last) begin
                  cmd.em_start = 1'b1;
                  st_in = S_EM;
               end
            end
         end
         S_EM: if (sts.em_done) st_in = S_OUT;
         S_OUT: begin
            cmd.clear = 1'b1;
            st_in = S_LOAD;
         end
         default: st_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= S_LOAD;
      else st_ff <= st_in;
   end

   assign busy = (st_ff != S_LOAD);
   assign rsp_valid = (st_ff == S_OUT);
endmodule

// ===== rtl/hwe_allele_freq_em.sv =====
// ----------------------------------------------------------------------------
// hwe_allele_freq_em: Hardy-Weinberg allele frequency EM estimator
// Collects one population's genotype likelihoods and reports the EM
// estimate of the alternate allele frequency.
// ----------------------------------------------------------------------------
// Usage:
//   Input: one sample item per cycle while busy is low (start & !busy).
//   Samples are stored, up to MaxSamples; extras are dropped. The item with
//   last_sample set closes the population and starts EM; busy stays high
//   until the result is out.
//   Each EM iteration first sets up its priors, then walks the store: a
//   missing sample or one with a zero weight sum needs no divide, a haploid
//   sample one serial divide and a diploid sample two; a final divide then
//   gives the new frequency (skipped if no allele was counted).
//   The result strobe follows the end of the last iteration, or follows the
//   closing item with no iteration run when there is no data or the
//   iteration limit is zero. The time to the result is data dependent.
//   Result: rsp_valid pulses one cycle with rsp_data; the receiver cannot
//   stall, so it must take the item in that cycle.
//   CSR: write max_iterations (0), epsilon (1), initial frequency (2) only
//   while idle; csr_ready is always high.
//   Reset (synchronous): store empty, registers to defaults.
// ----------------------------------------------------------------------------
module hwe_allele_freq_em
   import hwe_pkg::*;
#(
   parameter int MaxSamples = MaxSamplesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   logic [15:0] max_iter_ff;
   logic [31:0] eps_ff, init_ff;
   cmd_type     cmd;
   sts_type     sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= 16'd1000;
         eps_ff <= 32'd215;
         init_ff <= 32'h4000_0000;
      end else if (csr_valid) begin
         case (csr_index)
            CsrMaxIter:  max_iter_ff <= csr_wdata[15:0];
            CsrEpsilon:  eps_ff <= csr_wdata;
            CsrInitFreq: init_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   hwe_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .last(req_data.last_sample),
      .sts(sts), .cmd(cmd), .busy(busy), .rsp_valid(rsp_valid)
   );

   hwe_datapath #(.MaxSamples(MaxSamples)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req(req_data),
      .max_iter(max_iter_ff), .epsilon(eps_ff), .init_freq(init_ff),
      .sts(sts), .result(rsp_data)
   );

   // result strobe only while busy
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside busy");
   // after a result the block is ready again
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("not idle after result");
   // last sample accepted makes the block busy
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.last_sample) |=> busy)
      else $error("last sample did not start EM");
endmodule
